@@ src/bfa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the bitmap first-fit allocator.
// No dependencies; imported by bfa_ctrl, bfa_dpath and the top level.
package bfa_pkg;

    localparam int NUM_ENTRIES = 1024;
    localparam int WORD_BITS   = 32;
    localparam int NUM_WORDS   = (NUM_ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int WORD_W      = $clog2(NUM_WORDS);
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(NUM_ENTRIES);

    typedef enum logic [0:0] {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_FREED     = 2'd2,
        ST_REJECTED  = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        REG_TOTAL = 1'b0,
        REG_SKIP  = 1'b1
    } t_reg;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic commit;
        logic commit_none;
        logic retry;
    } t_cmd;

    typedef struct packed {
        logic is_alloc;
        logic word_found;
        logic hit;
        logic out_free;
    } t_stat;

endpackage

@@ src/bfa_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the allocator: accept, bitmap word search, check and commit.
// Depends on bfa_pkg; drives bfa_dpath through t_cmd and reads t_stat.
module bfa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bfa_pkg::t_stat i_stat,
    output bfa_pkg::t_cmd  o_cmd
);
    import bfa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEEK,
        S_CHECK
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SEEK;
                end
            end
            S_SEEK: begin
                if (!i_stat.is_alloc || i_stat.word_found) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_CHECK;
                end else if (i_stat.out_free) begin
                    o_cmd.commit_none = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_stat.is_alloc && !i_stat.hit) begin
                    o_cmd.retry = 1'b1;
                    n_state     = S_SEEK;
                end else if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/bfa_dpath.sv @@
`timescale 1ns / 1ps
// Datapath: bitmap word memory, full/valid summaries, count and result beat.
// Depends on bfa_pkg; sequenced by bfa_ctrl.
module bfa_dpath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bfa_pkg::t_cmd             i_cmd,
    output bfa_pkg::t_stat            o_stat,
    input  logic                      i_mode,
    input  logic [bfa_pkg::IDX_W-1:0] i_entry_index,
    input  logic [bfa_pkg::CNT_W-1:0] i_eff_total,
    input  logic                      i_skip_first,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_status,
    output logic [bfa_pkg::IDX_W-1:0] o_granted_index,
    output logic [bfa_pkg::CNT_W-1:0] o_free_count
);
    import bfa_pkg::*;

    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) r = BIT_W'(i);
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] lowest_word(input logic [NUM_WORDS-1:0] v);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (v[i]) r = WORD_W'(i);
        end
        return r;
    endfunction

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rvalid;
    logic [WORD_W-1:0]    r_rword;
    logic [NUM_WORDS-1:0] r_wvalid;
    logic [NUM_WORDS-1:0] r_full;
    logic [NUM_WORDS-1:0] r_tried;
    logic                 r_mode;
    logic [IDX_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_count;
    logic                 r_ovalid;
    logic [1:0]           r_status;
    logic [IDX_W-1:0]     r_grant;
    logic [CNT_W-1:0]     r_fc;

    logic [NUM_WORDS-1:0] avail;
    logic [WORD_W-1:0]    seek_w;
    logic                 word_found;
    logic [WORD_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] word_q;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] masked;
    logic                 alloc_hit;
    logic [BIT_W-1:0]     clear_pos;
    logic                 free_ok;
    logic [WORD_BITS-1:0] set_word;
    logic [WORD_BITS-1:0] clr_word;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     fc_next;
    logic [CNT_W-WORD_W-BIT_W-1:0] zpad;
    logic                 out_free;

    assign zpad       = '0;
    assign avail      = ~r_full & ~r_tried;
    assign seek_w     = lowest_word(avail);
    assign word_found = (|avail) && ({zpad, seek_w, BIT_W'(0)} < i_eff_total);
    assign rd_addr    = (r_mode == MODE_FREE) ? r_idx[IDX_W-1 -: WORD_W] : seek_w;
    assign word_q     = r_rvalid ? r_rdata : '0;

    always_comb begin
        if ({zpad, r_rword} < i_eff_total[CNT_W-1:BIT_W]) begin
            hi_mask = '0;
        end else if ({zpad, r_rword} == i_eff_total[CNT_W-1:BIT_W]) begin
            hi_mask = ~(({{(WORD_BITS-1){1'b0}}, 1'b1} << i_eff_total[BIT_W-1:0])
                        - {{(WORD_BITS-1){1'b0}}, 1'b1});
        end else begin
            hi_mask = '1;
        end
    end

    assign masked    = word_q | hi_mask
                     | {{(WORD_BITS-1){1'b0}}, (i_skip_first && (r_rword == '0))};
    assign alloc_hit = ~&masked;
    assign clear_pos = lowest_bit(~masked);
    assign free_ok   = ({1'b0, r_idx} < i_eff_total) && word_q[r_idx[BIT_W-1:0]];
    assign set_word  = word_q | ({{(WORD_BITS-1){1'b0}}, 1'b1} << clear_pos);
    assign clr_word  = word_q & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << r_idx[BIT_W-1:0]);
    assign out_free  = !r_ovalid || i_ready;

    always_comb begin
        n_count = r_count;
        if (i_cmd.commit) begin
            if (r_mode == MODE_ALLOC) begin
                n_count = r_count + CNT_W'(1);
            end else if (free_ok && (r_count != '0)) begin
                n_count = r_count - CNT_W'(1);
            end
        end
        fc_next = (n_count >= i_eff_total) ? '0 : (i_eff_total - n_count);
    end

    assign o_stat.is_alloc   = (r_mode == MODE_ALLOC);
    assign o_stat.word_found = word_found;
    assign o_stat.hit        = (r_mode == MODE_ALLOC) ? alloc_hit : free_ok;
    assign o_stat.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (i_cmd.commit) begin
            if (r_mode == MODE_ALLOC) begin
                r_mem[r_rword] <= set_word;
            end else if (free_ok) begin
                r_mem[r_rword] <= clr_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_idx  <= i_entry_index;
        end
        if (i_cmd.rd_en) begin
            r_rword  <= rd_addr;
            r_rvalid <= r_wvalid[rd_addr];
        end
        if (i_cmd.commit || i_cmd.commit_none) begin
            r_fc <= fc_next;
            if (i_cmd.commit_none) begin
                r_status <= ST_NO_SPACE;
                r_grant  <= '0;
            end else if (r_mode == MODE_ALLOC) begin
                r_status <= ST_ALLOCATED;
                r_grant  <= {r_rword, clear_pos};
            end else begin
                r_status <= free_ok ? ST_FREED : ST_REJECTED;
                r_grant  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
            r_full   <= '0;
            r_tried  <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.accept) begin
                r_tried <= '0;
            end else if (i_cmd.retry) begin
                r_tried[r_rword] <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_mode == MODE_ALLOC) begin
                    r_wvalid[r_rword] <= 1'b1;
                    r_full[r_rword]   <= &set_word;
                end else if (free_ok) begin
                    r_wvalid[r_rword] <= 1'b1;
                    r_full[r_rword]   <= 1'b0;
                end
            end
            if (i_cmd.commit || i_cmd.commit_none) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_status;
    assign o_granted_index = r_grant;
    assign o_free_count    = r_fc;

endmodule

@@ src/bitmap_first_fit_allocator.sv @@
`timescale 1ns / 1ps
// Bitmap first-fit allocator. Requests are handled one at a time: a free goes from its
// request beat through a word read and a check to its commit, and its result beat is
// registered at that commit. An allocate does the same, but each bitmap word that is
// read and turns out to have no usable free bit sends it back to search another word.
// There are at most two such words: the word that holds the reserved entry zero and the
// partial word at the total. An allocate that runs out of candidate words ends after
// the search. A result beat still waiting on i_ready holds the commit until it is taken.
// The bitmap sits in a single-port word memory with one registered read per word visit.
// Per-word full flags pick the word to read; per-word written flags make a word that was
// never written read as empty, so no clearing pass follows reset.
// Depends on bfa_pkg, bfa_ctrl and bfa_dpath.
module bitmap_first_fit_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_mode,
    input  logic [bfa_pkg::IDX_W-1:0]  i_entry_index,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic [bfa_pkg::IDX_W-1:0]  o_granted_index,
    output logic [bfa_pkg::CNT_W-1:0]  o_free_count,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bfa_pkg::ADDR_W-1:0] paddr,
    input  logic [bfa_pkg::DATA_W-1:0] pwdata,
    output logic [bfa_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import bfa_pkg::*;

    logic [CNT_W-1:0] r_total;
    logic             r_skip;
    logic [CNT_W-1:0] eff_total;
    logic             cfg_wr;
    t_reg             reg_sel;
    t_cmd             cmd;
    t_stat            stat;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign reg_sel   = t_reg'(paddr[2]);
    assign eff_total = (r_total > CAPACITY) ? CAPACITY : r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= CAPACITY;
            r_skip  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_TOTAL: r_total <= pwdata[CNT_W-1:0];
                REG_SKIP:  r_skip  <= pwdata[0];
                default:   r_skip  <= r_skip;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_TOTAL: prdata = {{(DATA_W-CNT_W){1'b0}}, r_total};
            REG_SKIP:  prdata = {{(DATA_W-1){1'b0}}, r_skip};
            default:   prdata = '0;
        endcase
    end

    bfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bfa_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_mode          (i_mode),
        .i_entry_index   (i_entry_index),
        .i_eff_total     (eff_total),
        .i_skip_first    (r_skip),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_free_count    (o_free_count)
    );

`ifndef NO_ASSERTIONS
    a_free_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_free_count <= eff_total))
        else $error("free count above effective total");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_ALLOCATED)) |-> (o_granted_index == '0))
        else $error("nonzero index on a beat that is not a grant");

    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.commit && stat.is_alloc) |=> ({1'b0, o_granted_index} < eff_total))
        else $error("granted index beyond effective total");
`endif

endmodule

@@ tb/bitmap_first_fit_allocator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_first_fit_allocator: random request beats,
// register settings over APB, and a first-fit bitmap predictor checked per beat.
// Depends on bfa_pkg and the bitmap_first_fit_allocator RTL.
module bitmap_first_fit_allocator_tb;
    import bfa_pkg::*;

    typedef struct packed {
        t_mode            mode;
        logic [IDX_W-1:0] idx;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] granted;
        logic [CNT_W-1:0] free_cnt;
    } t_resp;

    typedef struct packed {
        logic [NUM_ENTRIES-1:0] used;
        logic [CNT_W-1:0]       n_alloc;
        logic [CNT_W-1:0]       total;
        logic                   skip;
    } t_bitmap;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_mode = 1'b0;
    logic [IDX_W-1:0]   i_entry_index = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_status;
    logic [IDX_W-1:0]   o_granted_index;
    logic [CNT_W-1:0]   o_free_count;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    t_req               req_backlog[$];
    t_resp              resp_due[$];
    t_bitmap            dut_map;
    t_bitmap            plan_map;
    logic [IDX_W-1:0]   last_freed = '0;
    int                 idle_pct = 0;
    logic               no_idle = 1'b0;
    logic               hold_go = 1'b0;
    logic               rx_hold = 1'b0;
    int                 tx_gap = 0;
    int                 rx_gap = 0;
    int                 errors = 0;
    int                 n_beats = 0;
    int                 n_settings = 0;
    int                 n_status[4] = '{0, 0, 0, 0};

    bitmap_first_fit_allocator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_entry_index  (i_entry_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_granted_index(o_granted_index),
        .o_free_count   (o_free_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int eff_total(input t_bitmap m);
        return (int'(m.total) > NUM_ENTRIES) ? NUM_ENTRIES : int'(m.total);
    endfunction

    function automatic t_resp first_fit_step(inout t_bitmap m, input t_req rq);
        int    lim;
        int    cnt;
        t_resp r;
        lim       = eff_total(m);
        r.status  = ST_NO_SPACE;
        r.granted = '0;
        if (rq.mode == MODE_ALLOC) begin
            for (int i = (m.skip ? 1 : 0); i < lim; i++) begin
                if (!m.used[i]) begin
                    m.used[i] = 1'b1;
                    m.n_alloc = m.n_alloc + 1'b1;
                    r.status  = ST_ALLOCATED;
                    r.granted = IDX_W'(i);
                    break;
                end
            end
        end else if (int'(rq.idx) < lim && m.used[rq.idx]) begin
            m.used[rq.idx] = 1'b0;
            if (m.n_alloc != '0) m.n_alloc = m.n_alloc - 1'b1;
            r.status = ST_FREED;
        end else begin
            r.status = ST_REJECTED;
        end
        cnt        = int'(m.n_alloc);
        r.free_cnt = (cnt >= lim) ? '0 : CNT_W'(lim - cnt);
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] pick_used(input t_bitmap m);
        int lim;
        int start;
        int j;
        lim = eff_total(m);
        if (lim == 0) return IDX_W'($urandom_range(0, NUM_ENTRIES - 1));
        start = $urandom_range(0, lim - 1);
        for (int k = 0; k < lim; k++) begin
            j = (start + k) % lim;
            if (m.used[j]) return IDX_W'(j);
        end
        return IDX_W'(start);
    endfunction

    // Driver: hold the beat until accepted, then advance or idle for a burst.
    always @(posedge i_clk) begin
        t_req nxt;
        t_req cur;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (i_valid && o_ready) begin
                cur.mode = t_mode'(i_mode);
                cur.idx  = i_entry_index;
                resp_due.push_back(first_fit_step(dut_map, cur));
                n_beats++;
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap  <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (req_backlog.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
                    tx_gap  <= $urandom_range(0, 4);
                    i_valid <= 1'b0;
                end else begin
                    nxt           = req_backlog.pop_front();
                    i_valid       <= 1'b1;
                    i_mode        <= nxt.mode;
                    i_entry_index <= nxt.idx;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_gap  <= 0;
        end else if (rx_hold) begin
            i_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap  <= rx_gap - 1;
            i_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
            rx_gap  <= $urandom_range(0, 4);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_resp exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (resp_due.size() == 0) begin
                $error("unexpected result beat: status %0d index %0d free_count %0d",
                       o_status, o_granted_index, o_free_count);
                errors++;
            end else begin
                exp_r = resp_due.pop_front();
                n_status[exp_r.status]++;
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_status);
                    errors++;
                end
                if (o_granted_index !== exp_r.granted) begin
                    $error("granted_index: expected %0d, got %0d",
                           exp_r.granted, o_granted_index);
                    errors++;
                end
                if (o_free_count !== exp_r.free_cnt) begin
                    $error("free_count: expected %0d, got %0d",
                           exp_r.free_cnt, o_free_count);
                    errors++;
                end
            end
        end
    end

    // Starve the result side long enough to back up the request side.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("** bitmap_first_fit_allocator: FAILED **");
        $finish;
    end

    task automatic queue_req(input t_mode md, input logic [IDX_W-1:0] ix);
        t_req  rq;
        t_resp ignored;
        rq.mode = md;
        rq.idx  = ix;
        ignored = first_fit_step(plan_map, rq);
        req_backlog.push_back(rq);
        if (md == MODE_FREE) last_freed = ix;
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || i_valid || resp_due.size() != 0);
    endtask

    task automatic write_reg(input t_reg r, input logic [DATA_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(r));
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == REG_TOTAL) begin
            dut_map.total  = v[CNT_W-1:0];
            plan_map.total = v[CNT_W-1:0];
        end else begin
            dut_map.skip  = v[0];
            plan_map.skip = v[0];
        end
    endtask

    task automatic configure(input int total, input int skip);
        settle();
        write_reg(REG_TOTAL, DATA_W'(total));
        write_reg(REG_SKIP, DATA_W'(skip));
        n_settings++;
    endtask

    initial begin
        int ph_total[10];
        int ph_skip[10];
        int ph_items[10];
        int ph_alloc[10];
        int ph_idle[10];
        int sel;
        int sub;

        ph_total = '{40, 40, 1, 1, 0, 2047, 700, 33, 1024, 97};
        ph_skip  = '{0, 1, 0, 1, 1, 0, 1, 0, 0, 1};
        ph_items = '{150, 80, 30, 30, 20, 300, 250, 80, 250, 240};
        ph_alloc = '{60, 50, 50, 50, 50, 80, 80, 50, 60, 40};
        ph_idle  = '{30, 0, 40, 20, 20, 25, 50, 30, 30, 0};

        dut_map.used    = '0;
        dut_map.n_alloc = '0;
        dut_map.total   = CAPACITY;
        dut_map.skip    = 1'b0;
        plan_map        = dut_map;
        idle_pct        = 20;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_req(MODE_ALLOC, '0);
        queue_req(MODE_ALLOC, '0);
        queue_req(MODE_ALLOC, '0);
        queue_req(MODE_FREE, 10'd1);
        queue_req(MODE_FREE, 10'd1);
        queue_req(MODE_FREE, '1);
        queue_req(MODE_ALLOC, '1);
        configure(4, 1);
        queue_req(MODE_ALLOC, '0);
        queue_req(MODE_ALLOC, '0);
        queue_req(MODE_FREE, '0);
        queue_req(MODE_ALLOC, '0);
        configure(2, 1);
        queue_req(MODE_FREE, 10'd3);
        queue_req(MODE_ALLOC, '0);
        configure(0, 0);
        queue_req(MODE_ALLOC, '0);
        queue_req(MODE_FREE, '0);
        configure(2047, 0);
        queue_req(MODE_ALLOC, '1);
        queue_req(MODE_FREE, '1);
        queue_req(MODE_ALLOC, '0);

        for (int p = 0; p < 10; p++) begin
            configure(ph_total[p], ph_skip[p]);
            idle_pct = ph_idle[p];
            if (p == 9) no_idle = 1'b1;
            if (p == 5) hold_go = 1'b1;
            for (int n = 0; n < ph_items[p]; n++) begin
                sel = $urandom_range(0, 99);
                sub = $urandom_range(0, 9);
                if (sel < ph_alloc[p])
                    queue_req(MODE_ALLOC, IDX_W'($urandom_range(0, NUM_ENTRIES - 1)));
                else if (sub < 7)
                    queue_req(MODE_FREE, pick_used(plan_map));
                else if (sub < 9)
                    queue_req(MODE_FREE, IDX_W'($urandom_range(0, NUM_ENTRIES - 1)));
                else
                    queue_req(MODE_FREE, last_freed);
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (resp_due.size() != 0) begin
            $error("%0d result beats never arrived", resp_due.size());
            errors++;
        end
        $display("Run covered %0d request beats over %0d register settings.",
                 n_beats, n_settings);
        $display("Results: %0d grants, %0d full, %0d frees, %0d rejected frees.",
                 n_status[ST_ALLOCATED], n_status[ST_NO_SPACE],
                 n_status[ST_FREED], n_status[ST_REJECTED]);
        if (errors == 0) begin
            $display("** bitmap_first_fit_allocator: PASSED **");
        end else begin
            $display("** bitmap_first_fit_allocator: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/bfa_pkg.sv
src/bfa_ctrl.sv
src/bfa_dpath.sv
src/bitmap_first_fit_allocator.sv
tb/bitmap_first_fit_allocator_tb.sv
